// ----- design/fngem_pkg.sv -----
// ----------------------------------------------------------------------------
// fngem_pkg: shared types and constants of the four-neighbour edge map
// Payload structs, item mode codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package fngem_pkg;

   localparam int unsigned PIXEL_W    = 8;
   localparam int unsigned CFG_DATA_W = 11;
   localparam int unsigned CFG_IDX_W  = 2;

   localparam int unsigned MAX_WIDTH_DEFAULT  = 1024;
   localparam int unsigned MAX_HEIGHT_DEFAULT = 1024;

   // item mode codes
   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_DRAIN = 1'b1;

   // register indexes
   localparam logic [CFG_IDX_W-1:0] CSR_FRAME_WIDTH    = 2'd0;
   localparam logic [CFG_IDX_W-1:0] CSR_FRAME_HEIGHT   = 2'd1;
   localparam logic [CFG_IDX_W-1:0] CSR_EDGE_THRESHOLD = 2'd2;

   // register reset values
   localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RESET    = 11'd640;
   localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RESET   = 11'd480;
   localparam logic [PIXEL_W-1:0]    EDGE_THRESHOLD_RESET = 8'd74;

   typedef struct packed {
      logic               mode;
      logic [PIXEL_W-1:0] pixel;
   } req_type;

   typedef struct packed {
      logic edge_res;
      logic end_of_frame;
   } rsp_type;

   // which neighbours take part in the comparison of one item
   typedef struct packed {
      logic up_en;
      logic below_en;
      logic left_en;
      logic right_en;
      logic left_from_mid;
   } nbr_sel_type;

endpackage

// ----- design/fngem_ram.sv -----
// ----------------------------------------------------------------------------
// fngem_ram: generic line store
// One write port and two read ports with registered read data; a read of
// the address written at the same edge returns the new data.
// ----------------------------------------------------------------------------
module fngem_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]                            rd_data_a,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]                            rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : mem_ff[rd_addr_a];
      rd_b_ff <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- design/fngem_csr.sv -----
// ----------------------------------------------------------------------------
// fngem_csr: configuration registers
// Holds threshold and the clamped last column and last row of the frame;
// flags each write to these registers so the frame position can be cleared.
// ----------------------------------------------------------------------------
module fngem_csr #(
   parameter int unsigned MAX_WIDTH  = fngem_pkg::MAX_WIDTH_DEFAULT,
   parameter int unsigned MAX_HEIGHT = fngem_pkg::MAX_HEIGHT_DEFAULT,
   localparam int unsigned ADDR_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
   localparam int unsigned ROW_W     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fngem_pkg::CFG_IDX_W-1:0]      csr_index,
   input  logic [fngem_pkg::CFG_DATA_W-1:0]     csr_wdata,
   output logic                                 cfg_write,
   output logic [ADDR_W-1:0]                    last_col,
   output logic [ROW_W-1:0]                     last_row,
   output logic [fngem_pkg::PIXEL_W-1:0]        threshold
);

   logic [ADDR_W-1:0]             last_col_ff;
   logic [ROW_W-1:0]              last_row_ff;
   logic [fngem_pkg::PIXEL_W-1:0] threshold_ff;
   logic                          wr_hit;

   // last index of a dimension: zero counts as one, above the limit as the limit
   function automatic int unsigned last_index(
      input logic [fngem_pkg::CFG_DATA_W-1:0] value,
      input int unsigned                      limit
   );
      int unsigned v;
      v = 32'(value);
      if (v == 0) begin
         return 0;
      end
      if (v > limit) begin
         return limit - 1;
      end
      return v - 1;
   endfunction

   assign csr_ready = 1'b1;
   assign wr_hit    = csr_valid && csr_ready;
   assign cfg_write = wr_hit && (csr_index inside {fngem_pkg::CSR_FRAME_WIDTH,
                                                   fngem_pkg::CSR_FRAME_HEIGHT,
                                                   fngem_pkg::CSR_EDGE_THRESHOLD});

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff  <= ADDR_W'(last_index(fngem_pkg::FRAME_WIDTH_RESET, MAX_WIDTH));
         last_row_ff  <= ROW_W'(last_index(fngem_pkg::FRAME_HEIGHT_RESET, MAX_HEIGHT));
         threshold_ff <= fngem_pkg::EDGE_THRESHOLD_RESET;
      end else if (wr_hit) begin
         case (csr_index)
            fngem_pkg::CSR_FRAME_WIDTH: begin
               last_col_ff <= ADDR_W'(last_index(csr_wdata, MAX_WIDTH));
            end
            fngem_pkg::CSR_FRAME_HEIGHT: begin
               last_row_ff <= ROW_W'(last_index(csr_wdata, MAX_HEIGHT));
            end
            fngem_pkg::CSR_EDGE_THRESHOLD: begin
               threshold_ff <= csr_wdata[fngem_pkg::PIXEL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign last_col  = last_col_ff;
   assign last_row  = last_row_ff;
   assign threshold = threshold_ff;

endmodule

// ----- design/fngem_detect.sv -----
// ----------------------------------------------------------------------------
// fngem_detect: neighbour difference test
// Marks the center pixel as an edge when any enabled neighbour differs
// from it by more than the threshold.
// ----------------------------------------------------------------------------
module fngem_detect (
   input  fngem_pkg::nbr_sel_type          sel,
   input  logic [fngem_pkg::PIXEL_W-1:0]   center,
   input  logic [fngem_pkg::PIXEL_W-1:0]   up,
   input  logic [fngem_pkg::PIXEL_W-1:0]   below,
   input  logic [fngem_pkg::PIXEL_W-1:0]   left_upper,
   input  logic [fngem_pkg::PIXEL_W-1:0]   left_middle,
   input  logic [fngem_pkg::PIXEL_W-1:0]   right,
   input  logic [fngem_pkg::PIXEL_W-1:0]   threshold,
   output logic                            edge_res
);

   logic [fngem_pkg::PIXEL_W-1:0] left;

   function automatic logic exceeds(
      input logic [fngem_pkg::PIXEL_W-1:0] a,
      input logic [fngem_pkg::PIXEL_W-1:0] b,
      input logic [fngem_pkg::PIXEL_W-1:0] limit
   );
      logic [fngem_pkg::PIXEL_W-1:0] diff;
      diff = (a > b) ? (a - b) : (b - a);
      return diff > limit;
   endfunction

   // drain items take the left neighbour from the middle line
   assign left = sel.left_from_mid ? left_middle : left_upper;

   assign edge_res = (sel.up_en    && exceeds(center, up, threshold))
                  || (sel.below_en && exceeds(center, below, threshold))
                  || (sel.left_en  && exceeds(center, left, threshold))
                  || (sel.right_en && exceeds(center, right, threshold));

endmodule

// ----- design/four_neighbour_gradient_edge_map.sv -----
// Latency: a result is registered at the edge that accepts the item causing it
//    and is offered on the next cycle; a pixel's result comes with the pixel below.
// Throughput: one item per cycle while req_stall is low, set by the two-read-port
//    line stores that fetch the next item's neighbourhood in the cycle before it.
// Reset (synchronous): registers return to their reset values, frame position
//    and drain state clear; line stores keep their contents and need no sweep.
// ----------------------------------------------------------------------------
// four_neighbour_gradient_edge_map: raster edge map with two line stores
// Compares each pixel with its up, down, left and right neighbours against a
// programmable threshold and emits one result per pixel, one line late.
// ----------------------------------------------------------------------------
module four_neighbour_gradient_edge_map #(
   parameter int unsigned MAX_WIDTH  = fngem_pkg::MAX_WIDTH_DEFAULT,
   parameter int unsigned MAX_HEIGHT = fngem_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // pixel / drain items
   input  logic                             req_valid,
   output logic                             req_stall,
   input  fngem_pkg::req_type               req_data,
   // results
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output fngem_pkg::rsp_type               rsp_data,
   // configuration writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fngem_pkg::CFG_IDX_W-1:0]  csr_index,
   input  logic [fngem_pkg::CFG_DATA_W-1:0] csr_wdata
);

   localparam int unsigned ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int unsigned ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int unsigned PW     = fngem_pkg::PIXEL_W;

   // configuration
   logic              cfg_write;
   logic [ADDR_W-1:0] last_col;
   logic [ROW_W-1:0]  last_row;
   logic [PW-1:0]     threshold;

   // frame position: next incoming pixel and next drained result
   logic [ADDR_W-1:0] in_col_ff,  in_col_in;
   logic [ROW_W-1:0]  in_row_ff,  in_row_in;
   logic [ADDR_W-1:0] out_col_ff, out_col_in;
   logic              drain_ff,   drain_in;
   logic [PW-1:0]     prev_mid_ff;

   // line store ports
   logic [ADDR_W-1:0] rd_base;
   logic [PW-1:0]     mid_c, mid_r, up_c, up_l;
   logic              mid_we, up_we;

   // item handling
   logic                   accept;
   logic                   is_drain;
   logic                   emit;
   logic                   eof;
   logic                   edge_res;
   fngem_pkg::nbr_sel_type sel;

   // result register
   logic               rsp_valid_ff;
   fngem_pkg::rsp_type rsp_data_ff;
   logic               out_free;

   fngem_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg_write (cfg_write),
      .last_col  (last_col),
      .last_row  (last_row),
      .threshold (threshold)
   );

   // Accept whenever the result register is empty or is being emptied this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !out_free;
   assign accept    = req_valid && !req_stall;
   assign is_drain  = (req_data.mode == fngem_pkg::MODE_DRAIN);

   // Advance the frame position. A config write aborts the frame; a pixel
   // drops whatever drain results are still owed.
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      drain_in   = drain_ff;
      if (cfg_write) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         drain_in   = 1'b0;
      end else if (accept) begin
         if (is_drain) begin
            if (drain_ff) begin
               out_col_in = out_col_ff + ADDR_W'(1);
               if (out_col_ff == last_col) begin
                  drain_in = 1'b0;
               end
            end
         end else begin
            drain_in = 1'b0;
            if (in_col_ff == last_col) begin
               in_col_in = '0;
               if (in_row_ff == last_row) begin
                  // frame complete: last line now waits for drain items
                  in_row_in  = '0;
                  out_col_in = '0;
                  drain_in   = 1'b1;
               end else begin
                  in_row_in = in_row_ff + ROW_W'(1);
               end
            end else begin
               in_col_in = in_col_ff + ADDR_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         drain_ff   <= 1'b0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         drain_ff   <= drain_in;
      end
   end

   // Hold the center of the last drain: it is the next drain's left neighbour.
   always_ff @(posedge clock) begin
      if (accept && is_drain && drain_ff) begin
         prev_mid_ff <= mid_c;
      end
   end

   // Fetch the neighbourhood of the next item from the next-state position,
   // so the read data is ready the cycle that item shows up. While a drain is
   // owed the next item is read as a drain; a pixel then lands in line 0 and
   // needs nothing from the stores.
   assign rd_base = drain_in ? out_col_in : in_col_in;

   // Line 0 writes to the upper store are never read back; skip them.
   assign mid_we = accept && !is_drain;
   assign up_we  = mid_we && (in_row_ff != '0);

   fngem_ram #(
      .WIDTH (PW),
      .DEPTH (MAX_WIDTH)
   ) u_middle_line (
      .clock     (clock),
      .wr_en     (mid_we),
      .wr_addr   (in_col_ff),
      .wr_data   (req_data.pixel),
      .rd_addr_a (rd_base),
      .rd_data_a (mid_c),
      .rd_addr_b (rd_base + ADDR_W'(1)),
      .rd_data_b (mid_r)
   );

   fngem_ram #(
      .WIDTH (PW),
      .DEPTH (MAX_WIDTH)
   ) u_upper_line (
      .clock     (clock),
      .wr_en     (up_we),
      .wr_addr   (in_col_ff),
      .wr_data   (mid_c),
      .rd_addr_a (rd_base),
      .rd_data_a (up_c),
      .rd_addr_b (rd_base - ADDR_W'(1)),
      .rd_data_b (up_l)
   );

   // Pick the neighbours that exist for this item.
   always_comb begin
      if (is_drain) begin
         sel.up_en         = (last_row != '0);
         sel.below_en      = 1'b0;
         sel.left_en       = (out_col_ff != '0);
         sel.right_en      = (out_col_ff != last_col);
         sel.left_from_mid = 1'b1;
         emit              = drain_ff;
         eof               = (out_col_ff == last_col);
      end else begin
         sel.up_en         = (in_row_ff > ROW_W'(1));
         sel.below_en      = 1'b1;
         sel.left_en       = (in_col_ff != '0);
         sel.right_en      = (in_col_ff != last_col);
         sel.left_from_mid = 1'b0;
         emit              = (in_row_ff != '0);
         eof               = 1'b0;
      end
   end

   fngem_detect u_detect (
      .sel         (sel),
      .center      (mid_c),
      .up          (up_c),
      .below       (req_data.pixel),
      .left_upper  (up_l),
      .left_middle (prev_mid_ff),
      .right       (mid_r),
      .threshold   (threshold),
      .edge_res    (edge_res)
   );

   // Result register: load on a result, drop valid once the transfer is done.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= accept && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && accept && emit) begin
         rsp_data_ff.edge_res     <= edge_res;
         rsp_data_ff.end_of_frame <= eof;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A drain with nothing owed yields no result.
   a_idle_drain_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && is_drain && !drain_ff) |=> !rsp_valid)
      else $error("drain with nothing owed produced a result");

   // A pixel in the first line of a frame yields no result.
   a_line0_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_drain && (in_row_ff == '0)) |=> !rsp_valid)
      else $error("first-line pixel produced a result");

   // The end-of-frame result closes the drain.
   a_eof_ends_drain: assert property (@(posedge clock) disable iff (reset)
      (accept && is_drain && drain_ff && (out_col_ff == last_col)) |=>
         (!drain_ff && rsp_valid && rsp_data.end_of_frame))
      else $error("end of frame did not close the drain");

   // The input column and row stay inside the frame.
   a_col_in_line: assert property (@(posedge clock) disable iff (reset)
      (in_col_ff <= last_col) && (in_row_ff <= last_row))
      else $error("frame position outside the frame");

endmodule
